>>> src/mae_pkg.sv
// Shared types and constants for the monotonic alignment expectation block.
// No dependencies; used by the controller, the datapath and the top level.
package mae_pkg;

  localparam int FRAC_BITS   = 30;
  localparam int DATA_W      = FRAC_BITS + 1;
  localparam int SCAN_W      = 64;
  localparam int MUL_W       = 2 * DATA_W;
  localparam int DIV_W       = 2 * FRAC_BITS + 1;
  localparam int ACC_W       = MUL_W + DATA_W;
  localparam int ROW_LEN_W   = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;
  localparam int MAX_ROW_DEF = 1024;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST = ROW_LEN_W'(1024);
  localparam logic [DATA_W-1:0]    EPS_RST     = DATA_W'(1074);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EPS_FLOOR  = CFG_IDX_W'(1);

  typedef struct packed {
    logic accept;
    logic rd;
    logic load;
    logic div_step;
    logic add;
    logic mul_lo;
    logic mul_hi;
    logic finish;
  } mae_cmd_t;

  typedef struct packed {
    logic out_full;
  } mae_sts_t;

endpackage

>>> src/monotonic_alignment_expectation.sv
// Channel   Handshake              Payload
// in        in_valid_i/in_ready_o  choose_prob_i, sequence_start_i
// out       out_valid_o/out_ready_i alignment_o, row_end_o
// cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// Each item passes through read, load, divide, add, multiply and finish steps;
// the one-bit-per-cycle divider produces 2*FRAC_BITS+1 = 61 quotient bits.
// One item is in flight at a time; the next is accepted once the result is
// loaded into the output register, even while that result waits.
// Reset clears control state, sets config defaults; row memory is not cleared.
// A stalled output holds the last step until the output register drains.
// Top level; depends on mae_pkg, mae_ctrl and mae_dp.
module monotonic_alignment_expectation import mae_pkg::*; #(
  parameter int MaxRow = MAX_ROW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_W-1:0]     choose_prob_i,
  input  logic                  sequence_start_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_W-1:0]     alignment_o,
  output logic                  row_end_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  mae_cmd_t cmd;
  mae_sts_t sts;

  assign cfg_ready_o = 1'b1;

  mae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mae_dp #(.MaxRow(MaxRow)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .choose_prob_i    (choose_prob_i),
    .sequence_start_i (sequence_start_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .alignment_o      (alignment_o),
    .row_end_o        (row_end_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

endmodule

>>> src/mae_ctrl.sv
// Sequencing controller for the monotonic alignment expectation block.
// Depends on mae_pkg; drives commands into mae_dp.
module mae_ctrl import mae_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mae_sts_t sts_i,
  output mae_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_MLO  = 3'd5;
  localparam logic [2:0] S_MHI  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_MLO;
      end
      S_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MHI;
      end
      S_MHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> src/mae_dp.sv
// Datapath: row state, previous-row memory, shared multiplier, radix-2 divider,
// configuration registers and output register. Depends on mae_pkg.
module mae_dp import mae_pkg::*; #(
  parameter int MaxRow = MAX_ROW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mae_cmd_t              cmd_i,
  output mae_sts_t              sts_o,
  input  logic [DATA_W-1:0]     choose_prob_i,
  input  logic                  sequence_start_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_W-1:0]     alignment_o,
  output logic                  row_end_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PosW = $clog2(MaxRow);

  logic [DATA_W-1:0] mem [MaxRow];

  logic [ROW_LEN_W-1:0] row_len_q;
  logic [DATA_W-1:0]    eps_q;
  logic [DATA_W-1:0]    p_q, pp_q, prod_q, rd_q, dsr_q, rem_q;
  logic [SCAN_W-1:0]    scan_q;
  logic [PosW-1:0]      pos_q;
  logic                 first_q;
  logic [DIV_W-1:0]     div_q;
  logic [ACC_W-1:0]     acc_q;
  logic                 out_valid_q;
  logic [DATA_W-1:0]    align_q;
  logic                 row_end_q;

  logic [DATA_W-1:0] mul_a, mul_b, prev, floor_v, divisor, res;
  logic [MUL_W-1:0]  mul_p;
  logic [DATA_W:0]   trial;
  logic              q_bit;
  logic [SCAN_W:0]   sum;
  logic [31:0]       len, pos_nx;
  logic              last, scan_big;

  assign sts_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign alignment_o    = align_q;
  assign row_end_o      = row_end_q;

  always_comb begin
    mul_a = prod_q;
    mul_b = p_q;
    priority if (cmd_i.mul_lo) begin
      mul_a = {1'b0, scan_q[FRAC_BITS-1:0]} | (DATA_W'(scan_q[FRAC_BITS]) << FRAC_BITS);
      mul_b = pp_q;
    end else if (cmd_i.mul_hi) begin
      mul_a = {1'b0, scan_q[2*FRAC_BITS:DATA_W]};
      mul_b = pp_q;
    end else if (cmd_i.finish) begin
      mul_b = ONE_Q - p_q;
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    floor_v = eps_q;
    if (eps_q == '0) floor_v = DATA_W'(1);
    else if (eps_q > ONE_Q) floor_v = ONE_Q;
    divisor = prod_q;
    if (prod_q < floor_v) divisor = floor_v;
    else if (prod_q > ONE_Q) divisor = ONE_Q;
    if (first_q) prev = (pos_q == '0) ? ONE_Q : '0;
    else prev = rd_q;
  end

  assign trial = {rem_q, div_q[DIV_W-1]};
  assign q_bit = (trial >= {1'b0, dsr_q});
  assign sum   = {1'b0, scan_q} + (SCAN_W + 1)'(div_q);

  always_comb begin
    len = 32'(row_len_q);
    if (row_len_q == '0) len = 32'd1;
    else if (32'(row_len_q) > 32'(MaxRow)) len = 32'(MaxRow);
    pos_nx = 32'(pos_q) + 32'd1;
    last   = (pos_nx >= len);
  end

  assign scan_big = (|scan_q[SCAN_W-1:2*FRAC_BITS+1])
                 || (scan_q[2*FRAC_BITS] && (|scan_q[2*FRAC_BITS-1:0]));

  always_comb begin
    if (pp_q == '0) res = '0;
    else if (scan_big || (|acc_q[ACC_W-1:2*FRAC_BITS])) res = ONE_Q;
    else res = {1'b0, acc_q[2*FRAC_BITS-1:FRAC_BITS]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem[pos_q];
    if (cmd_i.finish) mem[pos_q] <= res;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      p_q <= (choose_prob_i > ONE_Q) ? ONE_Q : choose_prob_i;
    end
    if (cmd_i.load) begin
      pp_q  <= mul_p[2*FRAC_BITS:FRAC_BITS];
      dsr_q <= divisor;
      rem_q <= '0;
      div_q <= {prev[FRAC_BITS:0], {FRAC_BITS{1'b0}}};
    end
    if (cmd_i.div_step) begin
      rem_q <= q_bit ? DATA_W'(trial - {1'b0, dsr_q}) : trial[DATA_W-1:0];
      div_q <= {div_q[DIV_W-2:0], q_bit};
    end
    if (cmd_i.mul_lo) acc_q <= ACC_W'(mul_p);
    if (cmd_i.mul_hi) acc_q <= acc_q + (ACC_W'(mul_p) << DATA_W);
    if (cmd_i.finish) begin
      align_q   <= res;
      row_end_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q   <= ROW_LEN_RST;
      eps_q       <= EPS_RST;
      prod_q      <= ONE_Q;
      scan_q      <= '0;
      pos_q       <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_ROW_LENGTH: row_len_q <= cfg_data_i[ROW_LEN_W-1:0];
          REG_EPS_FLOOR:  eps_q     <= cfg_data_i[DATA_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept && sequence_start_i) begin
        prod_q  <= ONE_Q;
        scan_q  <= '0;
        pos_q   <= '0;
        first_q <= 1'b1;
      end
      if (cmd_i.add) begin
        scan_q <= sum[SCAN_W] ? '1 : sum[SCAN_W-1:0];
      end
      if (cmd_i.finish) begin
        if (last) begin
          prod_q  <= ONE_Q;
          scan_q  <= '0;
          pos_q   <= '0;
          first_q <= 1'b0;
        end else begin
          prod_q <= mul_p[2*FRAC_BITS:FRAC_BITS];
          pos_q  <= pos_q + 1'b1;
        end
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

>>> src/mae_checker.sv
// Port-level checker for monotonic_alignment_expectation, bound to the top.
// Depends on mae_pkg.
module mae_checker import mae_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DATA_W-1:0] alignment_o,
  input logic              row_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(alignment_o) && $stable(row_end_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> alignment_o <= ONE_Q)
    else $error("alignment above one");

endmodule

bind monotonic_alignment_expectation mae_checker u_mae_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .alignment_o (alignment_o),
  .row_end_o   (row_end_o)
);
